// ===== hdl/m2r_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// m2r_pkg
// Shared constants, codes and types for the mono to RGB565 subpixel scaler.
// ----------------------------------------------------------------------------
package m2r_pkg;

   // Source frame geometry (1 bit per pixel, MSB first)
   localparam int SRC_WIDTH   = 512;
   localparam int SRC_HEIGHT  = 342;
   localparam int ROW_BYTES   = SRC_WIDTH / 8;
   localparam int FRAME_BYTES = ROW_BYTES * SRC_HEIGHT;
   localparam int ADDR_W      = $clog2(FRAME_BYTES);
   localparam int COL_IDX_W   = $clog2(SRC_WIDTH);
   localparam int ROW_IDX_W   = $clog2(SRC_HEIGHT);

   // Item field widths
   localparam int STEP_W  = 7;
   localparam int COORD_W = 9;
   localparam int BYTE_W  = 8;
   localparam int PIX_W   = 16;

   // Position arithmetic, 1/32 source pixel units
   localparam int FRAC_W  = 5;
   localparam int POS_W   = COORD_W + STEP_W;
   localparam int CELL_W  = POS_W - FRAC_W;
   localparam int GRID_W  = CELL_W + 1;
   localparam int ACC_W   = 10;

   localparam logic [STEP_W-1:0] STEP_RESET  = 7'd51;
   localparam logic [FRAC_W-1:0] FRAC_MAX    = 5'd31;
   localparam logic [STEP_W-1:0] RED_EVEN_DY = 7'd10;

   // step / 3 as (step * 171) >> 9, exact for every 7-bit step
   localparam int                THIRD_SHIFT = 9;
   localparam logic [7:0]        THIRD_RECIP = 8'd171;

   // Shared multiplier operand and product widths
   localparam int MUL_A_W = COORD_W;
   localparam int MUL_B_W = STEP_W;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;

   // Operation codes
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   // Channel codes, in sampling order
   localparam logic [1:0] CH_RED   = 2'd0;
   localparam logic [1:0] CH_BLUE  = 2'd1;
   localparam logic [1:0] CH_GREEN = 2'd2;

   // Twelve reads: three channels of four corners
   localparam logic [3:0] LAST_READ = 4'd11;
   localparam logic [1:0] LAST_CORNER = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_X,
      ST_MUL_Y,
      ST_GRAB_Y,
      ST_READ,
      ST_DRAIN
   } seq_state_type;

endpackage : m2r_pkg
`default_nettype wire

// ===== hdl/mono_to_rgb565_subpixel_scaler.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mono_to_rgb565_subpixel_scaler
// Mono frame store with a bilinear, delta-subpixel RGB565 downscaler.
// ----------------------------------------------------------------------------
// A write (req_op = 0) stores one frame byte in the cycle it is accepted and
// leaves busy low, so writes can stream one per cycle. A query (req_op = 1)
// holds busy high through ST_MUL_X, ST_MUL_Y and ST_GRAB_Y, which form the two
// source positions through the shared multiplier, then ST_READ for twelve
// single-port frame store reads (four corners for each of three channels, one
// read per cycle, with the corner weight formed by the same multiplier
// alongside), and ST_DRAIN to fold in the last weight. rsp_valid pulses for
// one cycle right after busy drops and cannot be held off; the next
// transaction may be accepted in that same cycle. csr_ready is always high;
// change scale_step only while no query is in flight.
// ----------------------------------------------------------------------------
module mono_to_rgb565_subpixel_scaler
   import m2r_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   // Request channel
   input  wire logic               start,
   output logic                    busy,
   input  wire logic               req_op,
   input  wire logic [ADDR_W-1:0]  req_frame_addr,
   input  wire logic [BYTE_W-1:0]  req_frame_byte,
   input  wire logic [COORD_W-1:0] req_px,
   input  wire logic [COORD_W-1:0] req_py,
   // Response channel
   output logic                    rsp_valid,
   output logic [PIX_W-1:0]        rsp_pixel_rgb565,
   // Configuration write channel
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [STEP_W-1:0]  csr_scale_step
);

   seq_state_type state_ff, state_in;

   logic [3:0]          rd_cnt_ff, rd_cnt_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [COORD_W-1:0]  px_ff, px_in;
   logic [COORD_W-1:0]  py_ff, py_in;
   logic [POS_W-1:0]    sx_ff, sx_in;
   logic [POS_W-1:0]    sy_ff, sy_in;
   logic [ACC_W-1:0]    acc_ff, acc_in;
   logic                acc_vld_ff, acc_vld_in;
   logic [1:0]          acc_corner_ff, acc_corner_in;
   logic [1:0]          acc_chan_ff, acc_chan_in;
   logic                acc_oob_ff, acc_oob_in;
   logic [2:0]          acc_bit_ff, acc_bit_in;
   logic [4:0]          red_ff, red_in;
   logic [4:0]          blue_ff, blue_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [PIX_W-1:0]    rsp_pixel_ff, rsp_pixel_in;

   logic                accept;
   logic                write_hit;
   logic                odd_site;
   logic [1:0]          chan;
   logic [1:0]          corner;
   logic [14:0]         third_prod;
   logic [STEP_W-1:0]   third;
   logic [STEP_W-1:0]   third2;
   logic [STEP_W-1:0]   half;
   logic [STEP_W-1:0]   x_off;
   logic [STEP_W-1:0]   y_off;
   logic [POS_W-1:0]    pos_x;
   logic [POS_W-1:0]    pos_y;
   logic [GRID_W-1:0]   col;
   logic [GRID_W-1:0]   row;
   logic [FRAC_W-1:0]   fx;
   logic [FRAC_W-1:0]   fy;
   logic [FRAC_W-1:0]   wx;
   logic [FRAC_W-1:0]   wy;
   logic                oob;

   logic [MUL_A_W-1:0]  mul_a;
   logic [MUL_B_W-1:0]  mul_b;
   logic [PROD_W-1:0]   prod;

   logic                ram_we;
   logic [ADDR_W-1:0]   ram_addr;
   logic [BYTE_W-1:0]   ram_rdata;
   logic [2:0]          pix_idx;
   logic                pix_white;
   logic [ACC_W-1:0]    acc_sum;

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign write_hit = accept && (req_op == OP_WRITE) &&
                      (req_frame_addr < ADDR_W'(FRAME_BYTES));
   assign csr_ready = 1'b1;

   // ------------------------------------------------------------------------
   // Sample site for the current read
   // ------------------------------------------------------------------------
   assign odd_site   = px_ff[0] ^ py_ff[0];
   assign chan       = rd_cnt_ff[3:2];
   assign corner     = rd_cnt_ff[1:0];
   assign third_prod = 15'(step_ff) * 15'(THIRD_RECIP);
   assign third      = STEP_W'(third_prod[14:THIRD_SHIFT]);
   assign third2     = {third[STEP_W-2:0], 1'b0};
   assign half       = {1'b0, step_ff[STEP_W-1:1]};

   always_comb begin
      case (chan)
         CH_RED: begin
            x_off = '0;
            y_off = odd_site ? '0 : RED_EVEN_DY;
         end
         CH_BLUE: begin
            x_off = third2;
            y_off = odd_site ? '0 : step_ff;
         end
         CH_GREEN: begin
            x_off = third;
            y_off = odd_site ? half : '0;
         end
         default: begin
            x_off = '0;
            y_off = '0;
         end
      endcase
   end

   assign pos_x = sx_ff + POS_W'(x_off);
   assign pos_y = sy_ff + POS_W'(y_off);
   assign fx    = pos_x[FRAC_W-1:0];
   assign fy    = pos_y[FRAC_W-1:0];
   assign col   = GRID_W'(pos_x[POS_W-1:FRAC_W]) + GRID_W'(corner[0]);
   assign row   = GRID_W'(pos_y[POS_W-1:FRAC_W]) + GRID_W'(corner[1]);
   // Anything off the frame, including a missing lower row, reads as black
   assign oob   = (col >= GRID_W'(SRC_WIDTH)) || (row >= GRID_W'(SRC_HEIGHT));
   assign wx    = corner[0] ? fx : (FRAC_MAX - fx);
   assign wy    = corner[1] ? fy : (FRAC_MAX - fy);

   // ------------------------------------------------------------------------
   // Sequencer
   // ------------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (accept && (req_op == OP_QUERY)) state_in = ST_MUL_X;
         ST_MUL_X:  state_in = ST_MUL_Y;
         ST_MUL_Y:  state_in = ST_GRAB_Y;
         ST_GRAB_Y: state_in = ST_READ;
         ST_READ:   if (rd_cnt_ff == LAST_READ) state_in = ST_DRAIN;
         ST_DRAIN:  state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      mul_a    = px_ff;
      mul_b    = step_ff;
      ram_we   = 1'b0;
      ram_addr = req_frame_addr;
      unique case (state_ff)
         ST_IDLE: begin
            ram_we = write_hit;
         end
         ST_MUL_X: begin
            mul_a = px_ff;
         end
         ST_MUL_Y: begin
            mul_a = py_ff;
         end
         ST_READ: begin
            mul_a    = MUL_A_W'(wx);
            mul_b    = MUL_B_W'(wy);
            ram_addr = {row[ROW_IDX_W-1:0], col[COL_IDX_W-1:3]};
         end
         ST_GRAB_Y, ST_DRAIN: begin
            mul_a = px_ff;
         end
         default: begin
            mul_a = px_ff;
         end
      endcase
   end

   // ------------------------------------------------------------------------
   // Weight accumulation, in the cycle after the read
   // ------------------------------------------------------------------------
   assign pix_idx   = ~acc_bit_ff;
   assign pix_white = !acc_oob_ff && !ram_rdata[pix_idx];
   assign acc_sum   = acc_ff + (pix_white ? prod[ACC_W-1:0] : '0);

   always_comb begin
      px_in         = px_ff;
      py_in         = py_ff;
      sx_in         = sx_ff;
      sy_in         = sy_ff;
      rd_cnt_in     = '0;
      acc_in        = acc_ff;
      red_in        = red_ff;
      blue_in       = blue_ff;
      step_in       = step_ff;
      acc_vld_in    = (state_ff == ST_READ);
      acc_corner_in = corner;
      acc_chan_in   = chan;
      acc_oob_in    = oob;
      acc_bit_in    = col[2:0];
      rsp_valid_in  = (state_ff == ST_DRAIN);
      rsp_pixel_in  = {blue_ff, acc_sum[ACC_W-1:4], red_ff};

      if (csr_valid && csr_ready) begin
         step_in = csr_scale_step;
      end
      if (accept) begin
         px_in = req_px;
         py_in = req_py;
      end
      if (state_ff == ST_MUL_Y) begin
         sx_in = prod;
      end
      if (state_ff == ST_GRAB_Y) begin
         sy_in = prod;
      end
      if (state_ff == ST_READ) begin
         rd_cnt_in = rd_cnt_ff + 4'd1;
      end
      if (acc_vld_ff) begin
         acc_in = acc_sum;
         if (acc_corner_ff == LAST_CORNER) begin
            acc_in = '0;
            if (acc_chan_ff == CH_RED) begin
               red_in = acc_sum[ACC_W-1:5];
            end
            if (acc_chan_ff == CH_BLUE) begin
               blue_in = acc_sum[ACC_W-1:5];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_cnt_ff    <= '0;
         step_ff      <= STEP_RESET;
         acc_ff       <= '0;
         acc_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_cnt_ff    <= rd_cnt_in;
         step_ff      <= step_in;
         acc_ff       <= acc_in;
         acc_vld_ff   <= acc_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      px_ff         <= px_in;
      py_ff         <= py_in;
      sx_ff         <= sx_in;
      sy_ff         <= sy_in;
      acc_corner_ff <= acc_corner_in;
      acc_chan_ff   <= acc_chan_in;
      acc_oob_ff    <= acc_oob_in;
      acc_bit_ff    <= acc_bit_in;
      red_ff        <= red_in;
      blue_ff       <= blue_in;
      rsp_pixel_ff  <= rsp_pixel_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_pixel_rgb565 = rsp_pixel_ff;

   // ------------------------------------------------------------------------
   // Shared multiplier and frame store
   // ------------------------------------------------------------------------
   m2r_mul u_mul (
      .clock (clock),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .prod  (prod)
   );

   m2r_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (FRAME_BYTES)
   ) u_frame (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (req_frame_byte),
      .rdata (ram_rdata)
   );

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------
   a_rsp_after_drain: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == ST_DRAIN))
      else $error("response strobe without a finished query");

   a_query_starts: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_op == OP_QUERY)) |=> (state_ff == ST_MUL_X))
      else $error("accepted query did not start the sequencer");

   a_drain_is_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAIN) |->
         (acc_vld_ff && (acc_corner_ff == LAST_CORNER) && (acc_chan_ff == CH_GREEN)))
      else $error("drain cycle does not hold the last green corner");

   a_read_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |-> (rd_cnt_ff <= LAST_READ))
      else $error("read counter past last read");

   a_no_write_busy: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> ((state_ff == ST_IDLE) && start))
      else $error("frame store written while sequencer busy");

endmodule : mono_to_rgb565_subpixel_scaler
`default_nettype wire

// ===== hdl/m2r_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// m2r_ram
// Generic single-port RAM, one access per cycle, registered read; a write also reads the old word.
// ----------------------------------------------------------------------------
module m2r_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule : m2r_ram
`default_nettype wire

// ===== hdl/m2r_mul.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// m2r_mul
// Shared unsigned multiplier with registered product. Forms the source
// positions at query start and one bilinear corner weight per cycle after.
// ----------------------------------------------------------------------------
module m2r_mul
   import m2r_pkg::*;
(
   input  wire logic               clock,
   input  wire logic [MUL_A_W-1:0] op_a,
   input  wire logic [MUL_B_W-1:0] op_b,
   output logic      [PROD_W-1:0]  prod
);

   logic [PROD_W-1:0] prod_ff;
   logic [PROD_W-1:0] prod_in;

   assign prod_in = PROD_W'(op_a) * PROD_W'(op_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule : m2r_mul
`default_nettype wire

// ===== bench/m2r_pixel_checker.sv =====
// ----------------------------------------------------------------------------
// m2r_pixel_checker
// Watches the request, response and register channels of the scaler. It keeps
// a shadow copy of the frame store and of scale_step, predicts the RGB565
// pixel of every accepted query, and compares each response with the oldest
// prediction still outstanding.
// ----------------------------------------------------------------------------
module m2r_pixel_checker
   import m2r_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  logic               req_op,
   input  logic [ADDR_W-1:0]  req_frame_addr,
   input  logic [BYTE_W-1:0]  req_frame_byte,
   input  logic [COORD_W-1:0] req_px,
   input  logic [COORD_W-1:0] req_py,
   input  logic               rsp_valid,
   input  logic [PIX_W-1:0]   rsp_pixel_rgb565,
   input  logic               csr_valid,
   input  logic               csr_ready,
   input  logic [STEP_W-1:0]  csr_scale_step,
   output int unsigned        fault_count,
   output int unsigned        pixels_owed
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [COORD_W-1:0] px;
      logic [COORD_W-1:0] py;
      logic [PIX_W-1:0]   pixel;
   } pixel_query_type;

   logic [BYTE_W-1:0] frame_copy [FRAME_BYTES];
   logic [STEP_W-1:0] step_now = STEP_RESET;
   pixel_query_type   expected_pixels [$];
   pixel_query_type   oldest;
   int unsigned       faults = 0;
   int unsigned       owed = 0;

   assign fault_count = faults;
   assign pixels_owed = owed;

   task automatic flag_mismatch(input string what);
      $display("ERROR %0t ns: %s", $time, what);
      faults++;
   endtask

   // Anything outside the frame reads as black.
   function automatic bit is_dark(input int unsigned row, input int unsigned col);
      logic [BYTE_W-1:0] pix_byte;
      if (row >= SRC_HEIGHT || col >= SRC_WIDTH)
         return 1'b1;
      pix_byte = frame_copy[row * ROW_BYTES + (col >> 3)];
      return pix_byte[7 - (col & 7)];
   endfunction

   // Bilinear white weight at (x, y) in 1/32 source pixels, 0..961.
   function automatic int unsigned white_weight(input int unsigned x, input int unsigned y);
      int unsigned col, row, fx, fy, acc;
      col = x >> FRAC_W;
      row = y >> FRAC_W;
      fx  = x & FRAC_MAX;
      fy  = y & FRAC_MAX;
      acc = 0;
      if (row >= SRC_HEIGHT)
         return 0;
      if (!is_dark(row, col))
         acc += (FRAC_MAX - fx) * (FRAC_MAX - fy);
      if (!is_dark(row, col + 1))
         acc += fx * (FRAC_MAX - fy);
      // a lower row past the frame comes back black from is_dark
      if (!is_dark(row + 1, col))
         acc += (FRAC_MAX - fx) * fy;
      if (!is_dark(row + 1, col + 1))
         acc += fx * fy;
      return acc;
   endfunction

   function automatic logic [PIX_W-1:0] predict_pixel(input logic [COORD_W-1:0] qx,
                                                      input logic [COORD_W-1:0] qy);
      int unsigned s, sx, sy, third, red, green, blue;
      s     = step_now;
      sx    = qx * s;
      sy    = qy * s;
      third = s / 3;
      if (qx[0] ^ qy[0]) begin
         red   = white_weight(sx, sy);
         blue  = white_weight(sx + 2 * third, sy);
         green = white_weight(sx + third, sy + s / 2);
      end else begin
         red   = white_weight(sx, sy + RED_EVEN_DY);
         blue  = white_weight(sx + 2 * third, sy + s);
         green = white_weight(sx + third, sy);
      end
      return {blue[9:5], green[9:4], red[9:5]};
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         step_now = STEP_RESET;
         expected_pixels.delete();
      end else begin
         if (csr_valid && csr_ready)
            step_now = csr_scale_step;
         // retire the response before pushing a query taken at the same edge
         if (rsp_valid) begin
            if (expected_pixels.size() == 0) begin
               flag_mismatch($sformatf("pixel 0x%04h arrived with no query outstanding",
                                       rsp_pixel_rgb565));
            end else begin
               oldest = expected_pixels.pop_front();
               if (rsp_pixel_rgb565 !== oldest.pixel)
                  flag_mismatch($sformatf("query (%0d,%0d): pixel 0x%04h, expected 0x%04h",
                                          oldest.px, oldest.py, rsp_pixel_rgb565,
                                          oldest.pixel));
            end
         end
         if (start && !busy) begin
            if (req_op == OP_WRITE) begin
               if (req_frame_addr < FRAME_BYTES)
                  frame_copy[req_frame_addr] = req_frame_byte;
            end else begin
               expected_pixels.push_back('{px: req_px, py: req_py,
                                           pixel: predict_pixel(req_px, req_py)});
            end
         end
      end
      owed <= expected_pixels.size();
   end

endmodule : m2r_pixel_checker

// ===== bench/mono_to_rgb565_subpixel_scaler_test.sv =====
// ----------------------------------------------------------------------------
// mono_to_rgb565_subpixel_scaler_test
// Drives frame writes, pixel queries and scale_step writes into the scaler.
// Every query is preceded by writes of any frame byte it would read that has
// not been loaded yet. A directed set covers frame corners and edges; random
// phases then run at several scale steps, extremes included, with random sender
// gaps except at step 64. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module mono_to_rgb565_subpixel_scaler_test
   import m2r_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic               req_op = OP_WRITE;
   logic [ADDR_W-1:0]  req_frame_addr = '0;
   logic [BYTE_W-1:0]  req_frame_byte = '0;
   logic [COORD_W-1:0] req_px = '0;
   logic [COORD_W-1:0] req_py = '0;
   logic               rsp_valid;
   logic [PIX_W-1:0]   rsp_pixel_rgb565;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [STEP_W-1:0]  csr_scale_step = STEP_RESET;
   int unsigned        fault_count;
   int unsigned        pixels_owed;

   bit                 loaded [FRAME_BYTES];
   logic [STEP_W-1:0]  cur_step = STEP_RESET;
   int unsigned        item_total = 0;
   bit                 steady = 1'b0;

   mono_to_rgb565_subpixel_scaler dut (.*);

   m2r_pixel_checker checker_i (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_op           (req_op),
      .req_frame_addr   (req_frame_addr),
      .req_frame_byte   (req_frame_byte),
      .req_px           (req_px),
      .req_py           (req_py),
      .rsp_valid        (rsp_valid),
      .rsp_pixel_rgb565 (rsp_pixel_rgb565),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_scale_step   (csr_scale_step),
      .fault_count      (fault_count),
      .pixels_owed      (pixels_owed)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Drop start for a random gap now and then, sometimes long enough to span
   // a whole query.
   task automatic pace();
      int unsigned gap;
      if (!steady && $urandom_range(99) < 37) begin
         start <= 1'b0;
         gap = ($urandom_range(7) == 0) ? $urandom_range(24, 1) : $urandom_range(3, 1);
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_item(input logic op, input int unsigned addr,
                            input logic [BYTE_W-1:0] data,
                            input logic [COORD_W-1:0] qx, input logic [COORD_W-1:0] qy);
      start          <= 1'b1;
      req_op         <= op;
      req_frame_addr <= addr[ADDR_W-1:0];
      req_frame_byte <= data;
      req_px         <= qx;
      req_py         <= qy;
      do @(posedge clock); while (busy);
      if (op == OP_QUERY || addr < FRAME_BYTES)
         item_total++;
      if (op == OP_WRITE && addr < FRAME_BYTES)
         loaded[addr] = 1'b1;
      pace();
   endtask

   task automatic send_write(input int unsigned addr, input logic [BYTE_W-1:0] data);
      send_item(OP_WRITE, addr, data, $urandom_range(511), $urandom_range(511));
   endtask

   // Load every frame byte this query reads that holds nothing yet, then query.
   task automatic send_query(input logic [COORD_W-1:0] qx, input logic [COORD_W-1:0] qy);
      int unsigned s, sx, sy, third, addr;
      int unsigned xs [3];
      int unsigned ys [3];
      s     = cur_step;
      sx    = qx * s;
      sy    = qy * s;
      third = s / 3;
      if (qx[0] ^ qy[0]) begin
         xs = '{sx, sx + 2 * third, sx + third};
         ys = '{sy, sy, sy + s / 2};
      end else begin
         xs = '{sx, sx + 2 * third, sx + third};
         ys = '{sy + RED_EVEN_DY, sy + s, sy};
      end
      for (int k = 0; k < 3; k++) begin
         if ((ys[k] >> FRAC_W) < SRC_HEIGHT) begin
            for (int unsigned r = ys[k] >> FRAC_W; r <= (ys[k] >> FRAC_W) + 1; r++) begin
               for (int unsigned c = xs[k] >> FRAC_W; c <= (xs[k] >> FRAC_W) + 1; c++) begin
                  addr = r * ROW_BYTES + c / 8;
                  if (r < SRC_HEIGHT && c < SRC_WIDTH && !loaded[addr])
                     send_write(addr, $urandom_range(255));
               end
            end
         end
      end
      send_item(OP_QUERY, $urandom_range((1 << ADDR_W) - 1), $urandom_range(255), qx, qy);
   endtask

   // Hold the sender until every pixel is back, then let the block drain.
   task automatic settle(input int unsigned tail);
      start <= 1'b0;
      do @(posedge clock); while (pixels_owed != 0);
      repeat (tail) @(posedge clock);
   endtask

   task automatic set_step(input logic [STEP_W-1:0] value);
      settle(20);
      csr_valid      <= 1'b1;
      csr_scale_step <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      cur_step = value;
   endtask

   task automatic run_phase(input int unsigned quota);
      int unsigned stop_at, lim_x, lim_y, base_x, base_y, pick, row, col;
      stop_at = item_total + quota;
      lim_x   = 511;
      lim_y   = 511;
      // output coordinate whose source reaches the frame edge or just past it
      if (cur_step != 0) begin
         if ((SRC_WIDTH << FRAC_W) / cur_step < lim_x)
            lim_x = (SRC_WIDTH << FRAC_W) / cur_step;
         if ((SRC_HEIGHT << FRAC_W) / cur_step < lim_y)
            lim_y = (SRC_HEIGHT << FRAC_W) / cur_step;
      end
      base_x = $urandom_range(lim_x);
      base_y = $urandom_range(lim_y);
      while (item_total < stop_at) begin
         pick = $urandom_range(99);
         if (pick < 3) begin
            base_x = $urandom_range(lim_x);
            base_y = $urandom_range(lim_y);
         end
         if (pick < 60) begin
            send_query(base_x + $urandom_range(11), base_y + $urandom_range(11));
         end else if (pick < 68) begin
            send_query($urandom_range(511), $urandom_range(511));
         end else if (pick < 78) begin
            send_query(lim_x + $urandom_range(4) - 2,
                       $urandom_range(1) ? lim_y + $urandom_range(4) - 2 : base_y);
         end else if (pick < 88) begin
            // overwrite bytes under the current window
            row = ((base_y * cur_step) >> FRAC_W) + $urandom_range(3);
            col = ((base_x * cur_step) >> FRAC_W) + 8 * $urandom_range(2);
            if (row < SRC_HEIGHT && col < SRC_WIDTH)
               send_write(row * ROW_BYTES + col / 8, $urandom_range(255));
            else
               send_write($urandom_range(FRAME_BYTES - 1), $urandom_range(255));
         end else if (pick < 95) begin
            send_write($urandom_range(FRAME_BYTES - 1), $urandom_range(255));
         end else begin
            send_write($urandom_range((1 << ADDR_W) - 1), $urandom_range(255));
         end
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed: store bounds, frame corners, last row, last column.
      send_write(0, 8'hFF);
      send_write(FRAME_BYTES - 1, 8'h00);
      send_write(FRAME_BYTES, 8'hA5);
      send_write((1 << ADDR_W) - 1, 8'h5A);
      send_query(0, 0);
      send_query(1, 0);
      send_query(321, 214);
      send_query(320, 214);
      send_query(321, 100);
      send_query(100, 214);
      send_query(0, 319);
      send_query(319, 319);
      send_query(511, 511);
      send_query(511, 0);

      set_step(7'd32);
      run_phase(190);
      steady = 1'b1;
      set_step(7'd64);
      run_phase(190);
      steady = 1'b0;
      set_step(7'd0);
      run_phase(95);
      settle(0);
      run_phase(95);
      set_step(7'd127);
      run_phase(190);
      set_step($urandom_range(63, 33));
      run_phase(190);
      set_step(STEP_RESET);
      run_phase(190);

      settle(40);
      if (fault_count == 0)
         $display("mono_to_rgb565_subpixel_scaler verification clean");
      else
         $display("mono_to_rgb565_subpixel_scaler verification failed");
      $finish;
   end

   initial begin
      #8_000_000;
      $display("mono_to_rgb565_subpixel_scaler verification failed");
      $finish;
   end

endmodule : mono_to_rgb565_subpixel_scaler_test

// ===== filelist.f =====
hdl/m2r_pkg.sv
hdl/m2r_ram.sv
hdl/m2r_mul.sv
hdl/mono_to_rgb565_subpixel_scaler.sv
bench/m2r_pixel_checker.sv
bench/mono_to_rgb565_subpixel_scaler_test.sv
